// ===== hdl/wing_flap_controller_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Wing flap controller assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef WING_FLAP_CONTROLLER_UNIT_MACROS_SVH
`define WING_FLAP_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication.
`define WFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wfc: same-cycle check failed");

// Next-cycle implication.
`define WFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wfc: next-cycle check failed");

`endif

// ===== hdl/wfc_pkg.sv =====
// ---------------------------------------------------------------------------
// Wing flap controller package
// Types, codes and constants shared by the controller, datapath and top.
// ---------------------------------------------------------------------------
package wfc_pkg;

  localparam int unsigned NUM_W   = 18;  // 1000 * 255 fits in 18 bits
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned PWM_W   = 12;
  localparam int unsigned NOW_W   = 32;

  localparam logic [NUM_W-1:0] FLAP_SCALE = 18'd1000;
  localparam logic [7:0]       CNT_FULL   = 8'd255;

  // Register indexes
  localparam logic [2:0] REG_MAX_FREQ  = 3'd0;
  localparam logic [2:0] REG_PWM_TOP   = 3'd1;
  localparam logic [2:0] REG_PWM_BOT   = 3'd2;
  localparam logic [2:0] REG_PWM_MID   = 3'd3;
  localparam logic [2:0] REG_LANDING   = 3'd4;
  localparam logic [2:0] REG_TMO_LIMIT = 3'd5;
  localparam logic [2:0] REG_REL_GAP   = 3'd6;

  // Register reset values
  localparam logic [7:0]       RST_MAX_FREQ  = 8'd10;
  localparam logic [PWM_W-1:0] RST_PWM_TOP   = 12'd2152;
  localparam logic [PWM_W-1:0] RST_PWM_BOT   = 12'd1737;
  localparam logic [PWM_W-1:0] RST_PWM_MID   = 12'd1875;
  localparam logic [7:0]       RST_TMO_LIMIT = 8'd255;
  localparam logic [15:0]      RST_REL_GAP   = 16'd1000;

  typedef enum logic [1:0] {
    POSE_TOP    = 2'd0,
    POSE_MIDDLE = 2'd1,
    POSE_BOTTOM = 2'd2
  } pose_e;

  typedef enum logic [1:0] {
    RADIO_NONE      = 2'd0,
    RADIO_POLL_LOST = 2'd1,
    RADIO_COMMAND   = 2'd2
  } radio_e;

  typedef struct packed {
    logic [7:0]       max_frequency;
    logic [PWM_W-1:0] pwm_top;
    logic [PWM_W-1:0] pwm_bottom;
    logic [PWM_W-1:0] pwm_middle;
    logic             landing_enable;
    logic [7:0]       timeout_limit;
    logic [15:0]      release_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic load;       // capture the input request
    logic sw_upd;     // apply the run switch sample
    logic div_start;  // launch the toggle period division
    logic wing_upd;   // update wings and radio state
    logic push;       // copy the result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

// ===== hdl/wfc_div.sv =====
// ---------------------------------------------------------------------------
// Wing flap serial divider
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
module wfc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wfc_pkg::NUM_W-1:0]   num_i,
  input  logic [wfc_pkg::SPEED_W-1:0] den_i,
  output logic [wfc_pkg::NUM_W-1:0]   quo_o,
  output logic                        done_o
);

  localparam int unsigned CNT_W = $clog2(wfc_pkg::NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(wfc_pkg::NUM_W - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [wfc_pkg::SPEED_W-1:0] rem_q, rem_d;
  logic [wfc_pkg::NUM_W-1:0]   quo_q, quo_d;
  logic [wfc_pkg::SPEED_W-1:0] den_q, den_d;
  logic [wfc_pkg::SPEED_W:0]   trial;
  logic                        fits;

  assign trial = {rem_q, quo_q[wfc_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? wfc_pkg::SPEED_W'(trial - {1'b0, den_q})
                   : trial[wfc_pkg::SPEED_W-1:0];
      quo_d = {quo_q[wfc_pkg::NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== hdl/wfc_datapath.sv =====
// ---------------------------------------------------------------------------
// Wing flap datapath
// Loop state, switch and wing updates, radio count and the result register.
// ---------------------------------------------------------------------------
module wfc_datapath #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wfc_pkg::cfg_t               cfg_i,
  input  wfc_pkg::cmd_t               cmd_i,
  output wfc_pkg::stat_t              stat_o,
  input  logic [wfc_pkg::NOW_W-1:0]   now_ms_i,
  input  logic                        switch_pressed_i,
  input  logic [wfc_pkg::SPEED_W-1:0] speed_i,
  input  logic [1:0]                  radio_event_i,
  input  logic                        run_toggle_i,
  output logic [wfc_pkg::PWM_W-1:0]   wing_a_pwm_o,
  output logic [wfc_pkg::PWM_W-1:0]   wing_b_pwm_o,
  output logic                        running_now_o,
  output logic [1:0]                  wing_position_o
);

  // Captured request
  logic [TIME_BITS-1:0]        now_q;
  logic                        pressed_q;
  logic [wfc_pkg::SPEED_W-1:0] speed_q;
  wfc_pkg::radio_e             radio_q;
  logic                        toggle_q;

  // Loop state
  logic                      running_q, running_d;
  wfc_pkg::pose_e            pose_q, pose_d;
  logic [TIME_BITS-1:0]      last_toggle_q, last_toggle_d;
  logic [TIME_BITS-1:0]      last_press_q, last_press_d;
  logic [7:0]                tmo_cnt_q, tmo_cnt_d;
  logic [wfc_pkg::PWM_W-1:0] pwm_a_q, pwm_a_d;
  logic [wfc_pkg::PWM_W-1:0] pwm_b_q, pwm_b_d;

  // Result register
  logic [wfc_pkg::PWM_W-1:0] out_a_q, out_b_q;
  logic                      out_run_q;
  logic [1:0]                out_pose_q;

  logic [wfc_pkg::NUM_W-1:0] div_num;
  logic [wfc_pkg::NUM_W-1:0] div_quo;
  logic [wfc_pkg::NUM_W-1:0] flap_gap;
  logic [TIME_BITS-1:0]      press_limit;
  logic [TIME_BITS-1:0]      flip_due;
  logic                      landed;
  wfc_pkg::pose_e            flip_pose;

  assign div_num = wfc_pkg::NUM_W'(cfg_i.max_frequency) * wfc_pkg::FLAP_SCALE;

  wfc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (speed_q),
    .quo_o   (div_quo),
    .done_o  (stat_o.div_done)
  );

  // Halve the quotient: floor(floor(a/b)/2) == floor(a/(2b))
  assign flap_gap    = div_quo >> 1;
  assign press_limit = last_press_q + TIME_BITS'(cfg_i.release_gap_ms);
  assign flip_due    = last_toggle_q + TIME_BITS'(flap_gap);
  assign landed      = !running_q ||
                       (cfg_i.landing_enable && (tmo_cnt_q > cfg_i.timeout_limit));
  assign flip_pose   = (pose_q == wfc_pkg::POSE_TOP) ? wfc_pkg::POSE_BOTTOM
                                                      : wfc_pkg::POSE_TOP;

  always_comb begin
    running_d     = running_q;
    pose_d        = pose_q;
    last_toggle_d = last_toggle_q;
    last_press_d  = last_press_q;
    tmo_cnt_d     = tmo_cnt_q;
    pwm_a_d       = pwm_a_q;
    pwm_b_d       = pwm_b_q;

    if (cmd_i.sw_upd && pressed_q) begin
      if (now_q > press_limit) begin
        running_d = !running_q;
      end
      last_press_d = now_q;
    end

    if (cmd_i.wing_upd) begin
      if (landed) begin
        pose_d  = wfc_pkg::POSE_MIDDLE;
        pwm_a_d = cfg_i.pwm_middle;
        pwm_b_d = cfg_i.pwm_middle;
      end else if (speed_q == '0) begin
        pose_d  = wfc_pkg::POSE_TOP;
        pwm_a_d = cfg_i.pwm_top;
        pwm_b_d = cfg_i.pwm_bottom;
      end else if (now_q >= flip_due) begin
        pose_d        = flip_pose;
        last_toggle_d = now_q;
        if (flip_pose == wfc_pkg::POSE_BOTTOM) begin
          pwm_a_d = cfg_i.pwm_bottom;
          pwm_b_d = cfg_i.pwm_top;
        end else begin
          pwm_a_d = cfg_i.pwm_top;
          pwm_b_d = cfg_i.pwm_bottom;
        end
      end

      case (radio_q)
        wfc_pkg::RADIO_POLL_LOST: begin
          if (cfg_i.landing_enable && (tmo_cnt_q != wfc_pkg::CNT_FULL)) begin
            tmo_cnt_d = tmo_cnt_q + 8'd1;
          end
        end
        wfc_pkg::RADIO_COMMAND: begin
          tmo_cnt_d = '0;
          if (toggle_q) begin
            running_d = !running_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      pose_q        <= wfc_pkg::POSE_MIDDLE;
      last_toggle_q <= '0;
      last_press_q  <= '0;
      tmo_cnt_q     <= '0;
      pwm_a_q       <= wfc_pkg::RST_PWM_MID;
      pwm_b_q       <= wfc_pkg::RST_PWM_MID;
    end else begin
      running_q     <= running_d;
      pose_q        <= pose_d;
      last_toggle_q <= last_toggle_d;
      last_press_q  <= last_press_d;
      tmo_cnt_q     <= tmo_cnt_d;
      pwm_a_q       <= pwm_a_d;
      pwm_b_q       <= pwm_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q     <= TIME_BITS'(now_ms_i);
      pressed_q <= switch_pressed_i;
      speed_q   <= speed_i;
      radio_q   <= wfc_pkg::radio_e'(radio_event_i);
      toggle_q  <= run_toggle_i;
    end
    if (cmd_i.push) begin
      out_a_q    <= pwm_a_q;
      out_b_q    <= pwm_b_q;
      out_run_q  <= running_q;
      out_pose_q <= pose_q;
    end
  end

  assign wing_a_pwm_o    = out_a_q;
  assign wing_b_pwm_o    = out_b_q;
  assign running_now_o   = out_run_q;
  assign wing_position_o = out_pose_q;

endmodule

// ===== hdl/wfc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Wing flap controller sequencer
// Steps one request through switch, divide and wing phases; owns out valid.
// ---------------------------------------------------------------------------
`include "wing_flap_controller_unit_macros.svh"

module wfc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wfc_pkg::cmd_t  cmd_o,
  input  wfc_pkg::stat_t stat_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SWITCH = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_WINGS  = 5'b01000,
    ST_PUSH   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   in_accept;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SWITCH;
        end
      end
      ST_SWITCH: begin
        cmd_o.sw_upd    = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat_i.div_done) begin
          state_d = ST_WINGS;
        end
      end
      ST_WINGS: begin
        cmd_o.wing_upd = 1'b1;
        state_d        = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `WFC_ASSERT_IMP(a_push_into_free_slot, cmd_o.push, !out_valid_q || out_ready_i)
  `WFC_ASSERT_NXT(a_accept_starts_switch, in_accept, state_q == ST_SWITCH)
  `WFC_ASSERT_NXT(a_divide_waits_done, (state_q == ST_DIVIDE) && !stat_i.div_done, state_q == ST_DIVIDE)
  `WFC_ASSERT_NXT(a_push_sets_valid, cmd_o.push, out_valid_q)

endmodule

// ===== hdl/wing_flap_controller_unit.sv =====
// ---------------------------------------------------------------------------
// Wing flap controller unit
// One request is one control loop pass: run switch, wing servo pose, radio.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Content
//   s_axis    in         tvalid/tready             time, switch, speed, radio
//   m_axis    out        tvalid/tready             wing compares, running, pose
//   apb       in         psel/penable, pready=1    seven config registers
//
// The result reaches the output register through these phases in order:
// switch update, 18 steps of the serial toggle period divider and its done
// pulse, wing and radio update, result push.
// A new request is taken once the previous one has been pushed; the output
// register holds the result while m_axis_tready is low, and the push waits
// only when that register is still full.
// Reset is asynchronous, active low; there is no clearing pass.
// ---------------------------------------------------------------------------
module wing_flap_controller_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] now_ms, [32] switch_pressed, [40:33] speed,
  // [42:41] radio_event, [43] run_toggle, [47:44] zero
  input  logic [47:0] s_axis_tdata,

  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] wing_a_pwm, [23:12] wing_b_pwm, [24] running_now,
  // [26:25] wing_position, [31:27] zero
  output logic [31:0] m_axis_tdata,

  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wfc_pkg::cfg_t  cfg_q, cfg_d;
  wfc_pkg::cmd_t  cmd;
  wfc_pkg::stat_t stat;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  logic [wfc_pkg::PWM_W-1:0] wing_a_pwm;
  logic [wfc_pkg::PWM_W-1:0] wing_b_pwm;
  logic                      running_now;
  logic [1:0]                wing_position;

  // Register file: word index from the byte address, writes on the access phase.
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        wfc_pkg::REG_MAX_FREQ:  cfg_d.max_frequency  = pwdata[7:0];
        wfc_pkg::REG_PWM_TOP:   cfg_d.pwm_top        = pwdata[11:0];
        wfc_pkg::REG_PWM_BOT:   cfg_d.pwm_bottom     = pwdata[11:0];
        wfc_pkg::REG_PWM_MID:   cfg_d.pwm_middle     = pwdata[11:0];
        wfc_pkg::REG_LANDING:   cfg_d.landing_enable = pwdata[0];
        wfc_pkg::REG_TMO_LIMIT: cfg_d.timeout_limit  = pwdata[7:0];
        wfc_pkg::REG_REL_GAP:   cfg_d.release_gap_ms = pwdata[15:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      wfc_pkg::REG_MAX_FREQ:  prdata = 32'(cfg_q.max_frequency);
      wfc_pkg::REG_PWM_TOP:   prdata = 32'(cfg_q.pwm_top);
      wfc_pkg::REG_PWM_BOT:   prdata = 32'(cfg_q.pwm_bottom);
      wfc_pkg::REG_PWM_MID:   prdata = 32'(cfg_q.pwm_middle);
      wfc_pkg::REG_LANDING:   prdata = 32'(cfg_q.landing_enable);
      wfc_pkg::REG_TMO_LIMIT: prdata = 32'(cfg_q.timeout_limit);
      wfc_pkg::REG_REL_GAP:   prdata = 32'(cfg_q.release_gap_ms);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frequency  <= wfc_pkg::RST_MAX_FREQ;
      cfg_q.pwm_top        <= wfc_pkg::RST_PWM_TOP;
      cfg_q.pwm_bottom     <= wfc_pkg::RST_PWM_BOT;
      cfg_q.pwm_middle     <= wfc_pkg::RST_PWM_MID;
      cfg_q.landing_enable <= 1'b0;
      cfg_q.timeout_limit  <= wfc_pkg::RST_TMO_LIMIT;
      cfg_q.release_gap_ms <= wfc_pkg::RST_REL_GAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer: walks each request through its phases and owns result valid.
  wfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Datapath: loop state, divider and the output register.
  wfc_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .now_ms_i         (s_axis_tdata[31:0]),
    .switch_pressed_i (s_axis_tdata[32]),
    .speed_i          (s_axis_tdata[40:33]),
    .radio_event_i    (s_axis_tdata[42:41]),
    .run_toggle_i     (s_axis_tdata[43]),
    .wing_a_pwm_o     (wing_a_pwm),
    .wing_b_pwm_o     (wing_b_pwm),
    .running_now_o    (running_now),
    .wing_position_o  (wing_position)
  );

  assign m_axis_tdata = {5'd0, wing_position, running_now, wing_b_pwm, wing_a_pwm};

endmodule
